// ===== src/spsm_pkg.sv =====
// Shared constants, codes and types of the slotted page space manager.
package spsm_pkg;

  localparam int PAGE_BYTES       = 4096;
  localparam int MAX_SLOTS        = 32;
  localparam int HEADER_BYTES     = 12;
  localparam int SLOT_ENTRY_BYTES = 8;

  localparam int IDX_W = 5;   // slot number
  localparam int CNT_W = 6;   // slot count, holds MAX_SLOTS itself
  localparam int LEN_W = 13;  // byte offsets and lengths
  localparam int SW    = 18;  // signed width for space arithmetic
  localparam int FREE_MAX = 8191;

  localparam int IN_W  = 24;
  localparam int OUT_W = 72;

  typedef enum logic [2:0] {
    OP_RESET  = 3'd0,
    OP_CREATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_UPDATE = 3'd3,
    OP_REMOVE = 3'd4,
    OP_LOOKUP = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADSLOT = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DEC      = 9'b000000010,
    S_EXEC     = 9'b000000100,
    S_SCAN_RD  = 9'b000001000,
    S_SCAN_CMP = 9'b000010000,
    S_SCAN_END = 9'b000100000,
    S_PLACE    = 9'b001000000,
    S_TRIM     = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             mv;
    logic [IDX_W-1:0] slot;
    logic [LEN_W-1:0] off;
    logic [LEN_W-1:0] size;
    logic [LEN_W-1:0] src;
    logic [LEN_W-1:0] dst;
    logic             last;
  } res_t;

endpackage

// ===== src/spsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read in the same cycle; read returns the old entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/slotted_page_space_manager_unit.sv =====
// Top level: slot directory of one slotted page with compaction sequencer.
//
//  channel | dir | fields
//  s_axis  | in  | tdata: operation, slot_index, record_size
//  m_axis  | out | tdata: status, result_slot, record_offset, result_size,
//          |     |        move_source, move_dest, free_space; tuser: is_move;
//          |     | tlast: last
//
// With a free output, reset page, create and operations rejected at decode pass through
// decode and emit; lookup and in-place update add an execute step, insert with room adds
// execute and place; remove adds execute and a trim step that walks back over the
// trailing empty slots. Compaction reads and compares each slot below slot_count in turn
// for every moved record and for the closing scan, a serial walk over the offset/length RAM.
// Reset clears the kinds and page counters. A stalled output
// holds the sequencer at its next result; the next operation is taken once
// the previous one has handed off its last result.
module slotted_page_space_manager_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // operation[2:0], slot_index[7:3], record_size[20:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // status[1:0], result_slot[6:2], record_offset[19:7],
                                 // result_size[32:20], move_source[45:33],
                                 // move_dest[58:46], free_space[71:59]
  output logic        m_tuser,   // is_move
  output logic        m_tlast    // last
);

  localparam int IW = spsm_pkg::IDX_W;
  localparam int CW = spsm_pkg::CNT_W;
  localparam int LW = spsm_pkg::LEN_W;
  localparam int SW = spsm_pkg::SW;
  localparam int NS = spsm_pkg::MAX_SLOTS;

  spsm_pkg::state_t state, ret;
  logic [2:0]    op;
  logic [IW-1:0] idx;
  logic [LW-1:0] size;
  logic [NS-1:0] kind;
  logic [NS-1:0] done;
  logic [CW-1:0] count;
  logic [LW-1:0] dstart;
  logic [LW-1:0] used;
  logic [LW-1:0] cds;
  logic [IW-1:0] scan_i;
  logic          found;
  logic [IW-1:0] best;
  logic [LW-1:0] best_off;
  logic [LW-1:0] best_len;
  spsm_pkg::res_t res;

  // RAM holds {offset, length} per slot
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [2*LW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [2*LW-1:0] ram_rdata;
  logic [LW-1:0] rd_off, rd_len;

  spsm_ram #(.WIDTH(2*LW), .DEPTH(NS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign rd_off = ram_rdata[2*LW-1:LW];
  assign rd_len = ram_rdata[LW-1:0];

  // Space figures
  logic signed [SW-1:0] free_now, gap_now, size_s;
  logic [LW-1:0] free_clamp;
  logic [LW-1:0] used_drop;
  logic [LW-1:0] cds_new;
  logic          valid_idx;
  logic          upd_shrink;
  logic          need_compact;
  logic          place_fit;

  always_comb begin
    free_now = SW'(spsm_pkg::PAGE_BYTES) - SW'(used) - SW'(spsm_pkg::HEADER_BYTES)
             - (SW'(count) + SW'(1)) * SW'(spsm_pkg::SLOT_ENTRY_BYTES);
    gap_now  = SW'(dstart) - SW'(spsm_pkg::HEADER_BYTES)
             - SW'(count) * SW'(spsm_pkg::SLOT_ENTRY_BYTES);
    size_s   = SW'(size);
    if (free_now < 0) free_clamp = '0;
    else if (free_now > SW'(spsm_pkg::FREE_MAX)) free_clamp = LW'(spsm_pkg::FREE_MAX);
    else free_clamp = free_now[LW-1:0];
    used_drop    = (used >= rd_len) ? used - rd_len : '0;
    cds_new      = (cds >= best_len) ? cds - best_len : '0;
    valid_idx    = {1'b0, idx} < count;
    upd_shrink   = size <= rd_len;
    need_compact = size_s > gap_now;
    place_fit    = !(size_s > gap_now);
  end

  // First empty slot below count
  logic          cr_found;
  logic [IW-1:0] cr_slot;
  always_comb begin
    cr_found = 1'b0;
    cr_slot  = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!kind[i] && (CW'(i) < count)) begin
        cr_found = 1'b1;
        cr_slot  = IW'(i);
      end
    end
  end

  // Steer RAM ports
  always_comb begin
    ram_raddr = (state == spsm_pkg::S_SCAN_RD) ? scan_i : idx;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {rd_off, size};
    case (state)
      spsm_pkg::S_EXEC: begin
        ram_we = (op == spsm_pkg::OP_UPDATE) && upd_shrink;
      end
      spsm_pkg::S_SCAN_END: begin
        ram_we    = found;
        ram_waddr = best;
        ram_wdata = {cds_new, best_len};
      end
      spsm_pkg::S_PLACE: begin
        ram_we    = place_fit;
        ram_wdata = {dstart - size, size};
      end
      default: ram_we = 1'b0;
    endcase
  end

  function automatic spsm_pkg::res_t mk(input logic [1:0] st, input logic mv,
      input logic [IW-1:0] sl, input logic [LW-1:0] of, input logic [LW-1:0] sz,
      input logic [LW-1:0] sr, input logic [LW-1:0] ds, input logic lt);
    spsm_pkg::res_t r;
    r.status = st; r.mv = mv; r.slot = sl; r.off = of; r.size = sz;
    r.src = sr; r.dst = ds; r.last = lt;
    return r;
  endfunction

  assign s_tready = (state == spsm_pkg::S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= spsm_pkg::S_IDLE;
      ret      <= spsm_pkg::S_IDLE;
      kind     <= '0;
      done     <= '0;
      count    <= '0;
      dstart   <= LW'(spsm_pkg::PAGE_BYTES);
      used     <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the output once taken, unless a new result is loaded now
      if (m_tvalid && m_tready && state != spsm_pkg::S_EMIT) m_tvalid <= 1'b0;
      case (state)
        spsm_pkg::S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[2:0];
            idx   <= s_tdata[7:3];
            size  <= s_tdata[20:8];
            state <= spsm_pkg::S_DEC;
          end
        end
        spsm_pkg::S_DEC: begin
          state <= spsm_pkg::S_EMIT;
          ret   <= spsm_pkg::S_IDLE;
          case (op)
            spsm_pkg::OP_RESET: begin
              kind   <= '0;
              count  <= '0;
              dstart <= LW'(spsm_pkg::PAGE_BYTES);
              used   <= '0;
              res    <= mk(spsm_pkg::ST_OK, 1'b0, '0, '0, '0, '0, '0, 1'b1);
            end
            spsm_pkg::OP_CREATE: begin
              if (cr_found) begin
                res <= mk(spsm_pkg::ST_OK, 1'b0, cr_slot, '0, '0, '0, '0, 1'b1);
              end else if (count >= CW'(NS)) begin
                res <= mk(spsm_pkg::ST_FULL, 1'b0, '0, '0, '0, '0, '0, 1'b1);
              end else begin
                kind[count[IW-1:0]] <= 1'b0;
                count <= count + 1'b1;
                res <= mk(spsm_pkg::ST_OK, 1'b0, count[IW-1:0], '0, '0, '0, '0, 1'b1);
              end
            end
            spsm_pkg::OP_INSERT, spsm_pkg::OP_UPDATE,
            spsm_pkg::OP_REMOVE, spsm_pkg::OP_LOOKUP: begin
              if (!valid_idx || (op != spsm_pkg::OP_INSERT && !kind[idx])) begin
                res <= mk(spsm_pkg::ST_BADSLOT, 1'b0, idx, '0, '0, '0, '0, 1'b1);
              end else begin
                state <= spsm_pkg::S_EXEC;
              end
            end
            default: begin
              res <= mk(spsm_pkg::ST_BADSLOT, 1'b0, '0, '0, '0, '0, '0, 1'b1);
            end
          endcase
        end
        spsm_pkg::S_EXEC: begin
          state <= spsm_pkg::S_EMIT;
          ret   <= spsm_pkg::S_IDLE;
          case (op)
            spsm_pkg::OP_INSERT, spsm_pkg::OP_UPDATE: begin
              if (op == spsm_pkg::OP_UPDATE && upd_shrink) begin
                used <= used - rd_len + size;
                res  <= mk(spsm_pkg::ST_OK, 1'b0, idx, rd_off, size, '0, '0, 1'b1);
              end else if (op == spsm_pkg::OP_UPDATE && (size_s > free_now)) begin
                res <= mk(spsm_pkg::ST_NOSPACE, 1'b0, idx, rd_off, rd_len, '0, '0, 1'b1);
              end else begin
                // Drop the old record, then compact if the gap is short
                if (kind[idx]) begin
                  used      <= used_drop;
                  kind[idx] <= 1'b0;
                end
                if (need_compact) begin
                  done   <= '0;
                  cds    <= LW'(spsm_pkg::PAGE_BYTES);
                  scan_i <= '0;
                  found  <= 1'b0;
                  state  <= spsm_pkg::S_SCAN_RD;
                end else begin
                  state <= spsm_pkg::S_PLACE;
                end
              end
            end
            spsm_pkg::OP_REMOVE: begin
              kind[idx] <= 1'b0;
              used      <= used_drop;
              state     <= spsm_pkg::S_TRIM;
            end
            default: begin
              res <= mk(spsm_pkg::ST_OK, 1'b0, idx, rd_off, rd_len, '0, '0, 1'b1);
            end
          endcase
        end
        spsm_pkg::S_TRIM: begin
          if (count != '0 && !kind[IW'(count - 1'b1)]) begin
            count <= count - 1'b1;
          end else begin
            res   <= mk(spsm_pkg::ST_OK, 1'b0, idx, '0, '0, '0, '0, 1'b1);
            ret   <= spsm_pkg::S_IDLE;
            state <= spsm_pkg::S_EMIT;
          end
        end
        spsm_pkg::S_SCAN_RD: begin
          state <= spsm_pkg::S_SCAN_CMP;
        end
        spsm_pkg::S_SCAN_CMP: begin
          // Keep the highest offset; ties keep the lower slot
          if (kind[scan_i] && !done[scan_i] && (!found || rd_off > best_off)) begin
            found    <= 1'b1;
            best     <= scan_i;
            best_off <= rd_off;
            best_len <= rd_len;
          end
          if (({1'b0, scan_i} + 1'b1) >= count) begin
            state <= spsm_pkg::S_SCAN_END;
          end else begin
            scan_i <= scan_i + 1'b1;
            state  <= spsm_pkg::S_SCAN_RD;
          end
        end
        spsm_pkg::S_SCAN_END: begin
          if (!found) begin
            dstart <= cds;
            state  <= spsm_pkg::S_PLACE;
          end else begin
            done[best] <= 1'b1;
            cds        <= cds_new;
            res    <= mk(spsm_pkg::ST_OK, 1'b1, best, cds_new, best_len,
                         best_off, cds_new, 1'b0);
            scan_i <= '0;
            found  <= 1'b0;
            ret    <= spsm_pkg::S_SCAN_RD;
            state  <= spsm_pkg::S_EMIT;
          end
        end
        spsm_pkg::S_PLACE: begin
          if (place_fit) begin
            kind[idx] <= 1'b1;
            dstart    <= dstart - size;
            used      <= used + size;
            res <= mk(spsm_pkg::ST_OK, 1'b0, idx, dstart - size, size, '0, '0, 1'b1);
          end else begin
            res <= mk(spsm_pkg::ST_NOSPACE, 1'b0, idx, '0, '0, '0, '0, 1'b1);
          end
          ret   <= spsm_pkg::S_IDLE;
          state <= spsm_pkg::S_EMIT;
        end
        spsm_pkg::S_EMIT: begin
          // Hand the staged result to the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {free_clamp, res.dst, res.src, res.size, res.off,
                         res.slot, res.status};
            m_tuser  <= res.mv;
            m_tlast  <= res.last;
            state    <= ret;
          end
        end
        default: state <= spsm_pkg::S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/spsm_chk.sv =====
// Port-level checker for the slotted page space manager, bound to the top level.
module spsm_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // No result right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // A move is never the final result
  a_move_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tlast)
    else $error("move marked last");

  // Moves always report ok status
  a_move_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[1:0] == 2'd0)
    else $error("move with error status");

  // One operation at a time
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("operation taken while busy");

endmodule

bind slotted_page_space_manager_unit spsm_chk u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .m_tuser(m_tuser), .m_tlast(m_tlast)
);
